FILE: rtl/idh_pkg.sv
// Shared types and constants of the impact detector with holdoff.
package idh_pkg;

  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;
  localparam int THR_BITS   = 11;
  localparam int HOLD_BITS  = 8;
  localparam int DELAY_BITS = 16;
  localparam int MAG_BITS   = 11;

  localparam logic [MAG_BITS-1:0]   MAG_MAX         = '1;
  localparam logic [THR_BITS-1:0]   THRESHOLD_RESET = 11'd20;
  localparam logic [HOLD_BITS-1:0]  HOLDOFF_RESET   = 8'd75;
  localparam logic [DELAY_BITS-1:0] DELAY_RESET     = 16'd15000;
  localparam logic [HOLD_BITS-1:0]  HOLDOFF_START   = 8'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_HOLDOFF   = 2'd1;
  localparam logic [1:0] REG_DELAY     = 2'd2;

  typedef struct packed {
    logic [THR_BITS-1:0]   threshold;
    logic [HOLD_BITS-1:0]  holdoff_ticks;
    logic [DELAY_BITS-1:0] alert_wait_ticks;
  } cfg_t;

endpackage

FILE: rtl/idh_if.sv
// Handshake channels for tick words and result words.
interface idh_tick_if #(parameter int SAMPLE_BITS = 10) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;
  logic [SAMPLE_BITS-1:0] z_sample;
  logic                   cancel;

  modport source (output valid, output x_sample, output y_sample, output z_sample,
                  output cancel, input ready);
  modport sink (input valid, input x_sample, input y_sample, input z_sample,
                input cancel, output ready);
endinterface

interface idh_result_if ();
  logic                          valid;
  logic                          ready;
  logic                          impact;
  logic [idh_pkg::MAG_BITS-1:0]  magnitude;
  logic                          alarm_on;
  logic                          send_alert;

  modport source (output valid, output impact, output magnitude, output alarm_on,
                  output send_alert, input ready);
  modport sink (input valid, input impact, input magnitude, input alarm_on,
                input send_alert, output ready);
endinterface

FILE: rtl/idh_cfg.sv
// APB-style configuration registers of the impact detector.
module idh_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [idh_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [idh_pkg::DATA_BITS-1:0]  pwdata,
  output logic [idh_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output idh_pkg::cfg_t                  cfg
);

  logic [1:0] index;
  logic       wr;

  assign index  = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold        <= idh_pkg::THRESHOLD_RESET;
      cfg.holdoff_ticks    <= idh_pkg::HOLDOFF_RESET;
      cfg.alert_wait_ticks <= idh_pkg::DELAY_RESET;
    end else if (wr) begin
      unique case (index)
        idh_pkg::REG_THRESHOLD: cfg.threshold <= pwdata[idh_pkg::THR_BITS-1:0];
        idh_pkg::REG_HOLDOFF:   cfg.holdoff_ticks <= pwdata[idh_pkg::HOLD_BITS-1:0];
        idh_pkg::REG_DELAY:     cfg.alert_wait_ticks <= pwdata[idh_pkg::DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      idh_pkg::REG_THRESHOLD: prdata = idh_pkg::DATA_BITS'(cfg.threshold);
      idh_pkg::REG_HOLDOFF:   prdata = idh_pkg::DATA_BITS'(cfg.holdoff_ticks);
      idh_pkg::REG_DELAY:     prdata = idh_pkg::DATA_BITS'(cfg.alert_wait_ticks);
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: rtl/idh_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module idh_sqrt #(
  parameter int ROOT_BITS = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*ROOT_BITS-1:0] radicand,
  output logic                   done,
  output logic [ROOT_BITS-1:0]   root
);

  localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

  logic [2*ROOT_BITS-1:0] rad;
  logic [ROOT_BITS-1:0]   rem;
  logic [CNT_BITS-1:0]    cnt;
  logic                   busy;
  logic [ROOT_BITS+1:0]   rem_shift;
  logic [ROOT_BITS+1:0]   trial;
  logic                   take;

  assign rem_shift = {rem, rad[2*ROOT_BITS-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign take      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(ROOT_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[2*ROOT_BITS-3:0], 2'b00};
      rem  <= take ? ROOT_BITS'(rem_shift - trial) : ROOT_BITS'(rem_shift);
      root <= {root[ROOT_BITS-2:0], take};
    end
  end

endmodule

FILE: rtl/impact_detector_with_holdoff_unit.sv
// Top level of the impact detector with holdoff and delayed alert.
// One tick word in, one result word out. A tick inside the holdoff goes from
// accept straight to its result load; a tick that runs detection takes the accept
// step, three passes of the shared squarer, SAMPLE_BITS + 1 steps of the
// one-bit-per-cycle square root, then hand-over and load.
// Ready is low while a tick is being worked on; a finished result waits in the
// output register. Config must be written over the APB-style port only while
// the block is idle; the block itself does not enforce this.
module impact_detector_with_holdoff_unit #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  idh_tick_if.sink                       tick,
  idh_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [idh_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [idh_pkg::DATA_BITS-1:0]  pwdata,
  output logic [idh_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);

  localparam int ROOT_BITS = SAMPLE_BITS + 1;
  localparam int SUM_BITS  = 2 * ROOT_BITS;
  localparam int CW = (ROOT_BITS > idh_pkg::MAG_BITS) ? ROOT_BITS : idh_pkg::MAG_BITS;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SQUARE = 4'b0010,
    S_ROOT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  idh_pkg::cfg_t cfg;

  logic [SAMPLE_BITS-1:0]         prev_x, prev_y, prev_z;
  logic [SAMPLE_BITS-1:0]         dx, dy, dz, dsel;
  logic [idh_pkg::HOLD_BITS-1:0]  holdoff_count, holdoff_dec;
  logic                           armed;
  logic [idh_pkg::DELAY_BITS-1:0] elapsed;
  logic                           detect, cancel_q;
  logic [1:0]                     sq_idx;
  logic [SUM_BITS-1:0]            acc, acc_next;
  logic [2*SAMPLE_BITS-1:0]       product;
  logic                           root_start, root_done;
  logic [ROOT_BITS-1:0]           root, mag;
  logic                           accept, load, hit;
  logic [CW-1:0]                  mag_ext;
  logic                           armed_a, alert;
  logic [idh_pkg::DELAY_BITS-1:0] elapsed_a;

  idh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  idh_sqrt #(.ROOT_BITS(ROOT_BITS)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (acc_next),
    .done     (root_done),
    .root     (root)
  );

  assign tick.ready = (state == S_IDLE);
  assign accept     = tick.valid && tick.ready;
  assign load       = (state == S_FINISH) && (!result.valid || result.ready);

  assign holdoff_dec = (holdoff_count == '0) ? '0 : holdoff_count - 1'b1;

  always_comb begin
    unique case (sq_idx)
      2'd0:    dsel = dx;
      2'd1:    dsel = dy;
      default: dsel = dz;
    endcase
  end

  assign product    = dsel * dsel;
  assign acc_next   = acc + SUM_BITS'(product);
  assign root_start = (state == S_SQUARE) && (sq_idx == 2'd2);

  assign mag_ext = CW'(mag);
  assign hit     = detect && (mag_ext >= CW'(cfg.threshold));

  always_comb begin
    armed_a   = armed;
    elapsed_a = elapsed;
    alert     = 1'b0;
    if (hit) begin
      armed_a   = 1'b1;
      elapsed_a = '0;
    end else if (armed && elapsed != '1) begin
      elapsed_a = elapsed + 1'b1;
    end
    if (armed_a && elapsed_a >= cfg.alert_wait_ticks) begin
      alert     = 1'b1;
      armed_a   = 1'b0;
      elapsed_a = '0;
    end
    if (cancel_q) begin
      armed_a   = 1'b0;
      elapsed_a = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev_x        <= '0;
      prev_y        <= '0;
      prev_z        <= '0;
      holdoff_count <= idh_pkg::HOLDOFF_START;
      armed         <= 1'b0;
      elapsed       <= '0;
      result.valid  <= 1'b0;
      sq_idx        <= '0;
      detect        <= 1'b0;
    end else begin
      result.valid <= load || (result.valid && !result.ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            holdoff_count <= holdoff_dec;
            prev_x        <= tick.x_sample;
            prev_y        <= tick.y_sample;
            prev_z        <= tick.z_sample;
            detect        <= (holdoff_dec == '0);
            sq_idx        <= '0;
            state         <= (holdoff_dec == '0) ? S_SQUARE : S_FINISH;
          end
        end
        S_SQUARE: begin
          sq_idx <= sq_idx + 1'b1;
          if (root_start) state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) state <= S_FINISH;
        end
        S_FINISH: begin
          if (load) begin
            armed        <= armed_a;
            elapsed      <= elapsed_a;
            if (hit) holdoff_count <= cfg.holdoff_ticks;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx       <= (tick.x_sample >= prev_x) ? tick.x_sample - prev_x : prev_x - tick.x_sample;
      dy       <= (tick.y_sample >= prev_y) ? tick.y_sample - prev_y : prev_y - tick.y_sample;
      dz       <= (tick.z_sample >= prev_z) ? tick.z_sample - prev_z : prev_z - tick.z_sample;
      cancel_q <= tick.cancel;
      acc      <= '0;
    end else if (state == S_SQUARE) begin
      acc <= acc_next;
    end
    if (state == S_ROOT && root_done) mag <= root;
    if (load) begin
      result.impact     <= hit;
      result.magnitude  <= !hit ? '0 :
                           (mag_ext > CW'(idh_pkg::MAG_MAX)) ? idh_pkg::MAG_MAX :
                           mag_ext[idh_pkg::MAG_BITS-1:0];
      result.alarm_on   <= armed_a;
      result.send_alert <= alert;
    end
  end

endmodule

FILE: tb/tb_impact_detector_with_holdoff_unit.sv
// Self-checking testbench for the impact detector with holdoff and delayed alert.
module tb_impact_detector_with_holdoff_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import idh_pkg::*;

  localparam int SAMPLE_BITS = 10;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int THR_MAX     = 1772;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 105;

  localparam logic [ADDR_BITS-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
  localparam logic [ADDR_BITS-1:0] ADDR_HOLDOFF   = {REG_HOLDOFF, 2'b00};
  localparam logic [ADDR_BITS-1:0] ADDR_DELAY     = {REG_DELAY, 2'b00};

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0] z;
    logic                   cancel;
  } tick_word_t;

  typedef struct packed {
    logic                impact;
    logic [MAG_BITS-1:0] magnitude;
    logic                alarm_on;
    logic                send_alert;
  } result_word_t;

  class impact_scoreboard;
    logic [THR_BITS-1:0]    threshold;
    logic [HOLD_BITS-1:0]   holdoff_ticks;
    logic [DELAY_BITS-1:0]  alert_wait;
    logic [SAMPLE_BITS-1:0] last_x, last_y, last_z;
    logic [HOLD_BITS-1:0]   holdoff_left;
    bit                     armed;
    logic [DELAY_BITS-1:0]  elapsed;
    result_word_t           pending_results[$];
    int                     failures, ticks, impacts, alerts, cancels;

    function new();
      threshold     = THRESHOLD_RESET;
      holdoff_ticks = HOLDOFF_RESET;
      alert_wait    = DELAY_RESET;
      last_x        = '0;
      last_y        = '0;
      last_z        = '0;
      holdoff_left  = HOLDOFF_START;
      armed         = 1'b0;
      elapsed       = '0;
      failures      = 0;
      ticks         = 0;
      impacts       = 0;
      alerts        = 0;
      cancels       = 0;
    endfunction

    function longint delta_squared(logic [SAMPLE_BITS-1:0] now_s, logic [SAMPLE_BITS-1:0] old_s);
      longint d;
      d = (now_s >= old_s) ? now_s - old_s : old_s - now_s;
      return d * d;
    endfunction

    function longint floor_root(longint v);
      longint r, c;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        c = r | (longint'(1) << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function void note_tick(tick_word_t t);
      result_word_t res;
      longint       mag;
      bit           hit, alert;
      res   = '0;
      hit   = 1'b0;
      alert = 1'b0;
      if (holdoff_left != 0) holdoff_left--;
      if (holdoff_left == 0) begin
        mag = floor_root(delta_squared(t.x, last_x) + delta_squared(t.y, last_y)
                         + delta_squared(t.z, last_z));
        if (mag >= threshold) begin
          hit           = 1'b1;
          holdoff_left  = holdoff_ticks;
          res.magnitude = (mag > MAG_MAX) ? MAG_MAX : mag[MAG_BITS-1:0];
        end
      end
      last_x = t.x;
      last_y = t.y;
      last_z = t.z;
      if (hit) begin
        armed   = 1'b1;
        elapsed = '0;
      end else if (armed && elapsed != '1) begin
        elapsed++;
      end
      if (armed && elapsed >= alert_wait) begin
        alert   = 1'b1;
        armed   = 1'b0;
        elapsed = '0;
      end
      if (t.cancel) begin
        armed   = 1'b0;
        elapsed = '0;
        cancels++;
      end
      res.impact     = hit;
      res.alarm_on   = armed;
      res.send_alert = alert;
      ticks++;
      if (hit) impacts++;
      if (alert) alerts++;
      pending_results.push_back(res);
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      if (pending_results.size() == 0) begin
        $error("result word with none pending: impact=%0d magnitude=%0d alarm_on=%0d send_alert=%0d",
               got.impact, got.magnitude, got.alarm_on, got.send_alert);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (got.impact !== want.impact) begin
        $error("impact: expected %0d, got %0d", want.impact, got.impact);
        failures++;
      end
      if (got.magnitude !== want.magnitude) begin
        $error("magnitude: expected %0d, got %0d", want.magnitude, got.magnitude);
        failures++;
      end
      if (got.alarm_on !== want.alarm_on) begin
        $error("alarm_on: expected %0d, got %0d", want.alarm_on, got.alarm_on);
        failures++;
      end
      if (got.send_alert !== want.send_alert) begin
        $error("send_alert: expected %0d, got %0d", want.send_alert, got.send_alert);
        failures++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  idh_tick_if #(.SAMPLE_BITS(SAMPLE_BITS)) tk ();
  idh_result_if rs ();

  impact_detector_with_holdoff_unit #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tk),
    .result  (rs),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  impact_scoreboard board = new();
  int burst_left = 0;
  int settings   = 0;
  int long_holds = 0;
  bit stall_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("impact_detector_with_holdoff_unit regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rs.valid && rs.ready)
      board.check_result({rs.impact, rs.magnitude, rs.alarm_on, rs.send_alert});
  end

  // receiver: stretches of steady, random and sparse ready, plus one long hold-off on request
  initial begin : result_sink
    int stretch;
    int mode;
    rs.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        long_holds++;
        rs.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(8, 48);
      repeat (stretch) begin
        case (mode)
          0:       rs.ready <= 1'b1;
          1:       rs.ready <= 1'($urandom_range(0, 1));
          default: rs.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_tick(int x, int y, int z, bit cancel);
    tick_word_t t;
    int         gap;
    t = {SAMPLE_BITS'(x), SAMPLE_BITS'(y), SAMPLE_BITS'(z), cancel};
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        tk.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    tk.valid    <= 1'b1;
    tk.x_sample <= t.x;
    tk.y_sample <= t.y;
    tk.z_sample <= t.z;
    tk.cancel   <= t.cancel;
    do @(posedge clk); while (!tk.ready);
    board.note_tick(t);
  endtask

  task automatic drain();
    tk.valid <= 1'b0;
    burst_left = 0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // leaves the bus in its access state; the caller returns it to idle
  task automatic reg_access(bit is_write, logic [ADDR_BITS-1:0] addr,
                            logic [DATA_BITS-1:0] wdata, logic [DATA_BITS-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!is_write && prdata !== want) begin
      $error("register %0d readback: expected %0d, got %0d", addr, want, prdata);
      board.failures++;
    end
  endtask

  task automatic write_cfg(int thr, int hold, int dly);
    logic [DATA_BITS-1:0] junk;
    junk = $urandom();
    reg_access(1'b1, ADDR_THRESHOLD, (junk & ~32'h7FF) | 32'(thr), '0);
    reg_access(1'b0, ADDR_THRESHOLD, '0, 32'(thr));
    junk = $urandom();
    reg_access(1'b1, ADDR_HOLDOFF, (junk & ~32'hFF) | 32'(hold), '0);
    reg_access(1'b0, ADDR_HOLDOFF, '0, 32'(hold));
    junk = $urandom();
    reg_access(1'b1, ADDR_DELAY, (junk & ~32'hFFFF) | 32'(dly), '0);
    reg_access(1'b0, ADDR_DELAY, '0, 32'(dly));
    psel    <= 1'b0;
    penable <= 1'b0;
    board.threshold     = THR_BITS'(thr);
    board.holdoff_ticks = HOLD_BITS'(hold);
    board.alert_wait    = DELAY_BITS'(dly);
    settings++;
  endtask

  initial begin : stimulus
    int thr, hold, dly;
    int pick;
    int base_x, base_y, base_z;
    int x, y, z;
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    tk.valid    <= 1'b0;
    tk.x_sample <= '0;
    tk.y_sample <= '0;
    tk.z_sample <= '0;
    tk.cancel   <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    reg_access(1'b0, ADDR_THRESHOLD, '0, 32'(THRESHOLD_RESET));
    reg_access(1'b0, ADDR_HOLDOFF, '0, 32'(HOLDOFF_RESET));
    reg_access(1'b0, ADDR_DELAY, '0, 32'(DELAY_RESET));
    psel    <= 1'b0;
    penable <= 1'b0;

    // zero threshold, no holdoff, zero delay: alert in the impact tick
    write_cfg(0, 0, 0);
    send_tick(0, 0, 0, 1'b0);
    send_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_tick(0, 0, 0, 1'b1);
    send_tick(SAMPLE_MAX, 0, SAMPLE_MAX, 1'b0);
    send_tick(SAMPLE_MAX, 0, SAMPLE_MAX, 1'b1);
    drain();

    // threshold out of reach
    write_cfg(THR_MAX, 1, 3);
    send_tick(0, SAMPLE_MAX, 0, 1'b0);
    send_tick(SAMPLE_MAX, 0, SAMPLE_MAX, 1'b0);
    send_tick(0, 0, 0, 1'b0);
    send_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    drain();

    // holdoff of one, short delay, cancel after and with an impact
    write_cfg(100, 1, 2);
    send_tick(500, 500, 500, 1'b0);
    send_tick(500, 500, 500, 1'b0);
    send_tick(501, 500, 500, 1'b0);
    send_tick(900, 100, 500, 1'b0);
    send_tick(900, 100, 500, 1'b1);
    send_tick(100, 900, 500, 1'b1);
    send_tick(100, 900, 500, 1'b0);
    drain();

    // longest delay, then shortened while the alarm is armed
    write_cfg(50, 3, 16'hFFFF);
    send_tick(0, 0, 0, 1'b0);
    send_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    drain();
    write_cfg(50, 3, 1);
    send_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_tick(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    drain();

    base_x = $urandom_range(0, SAMPLE_MAX);
    base_y = $urandom_range(0, SAMPLE_MAX);
    base_z = $urandom_range(0, SAMPLE_MAX);
    for (int phase = 0; phase < PHASES; phase++) begin
      thr  = $urandom_range(1, 60);
      hold = $urandom_range(0, 6);
      dly  = $urandom_range(0, 25);
      case (phase)
        0: thr  = 0;
        1: thr  = THR_MAX;
        2: dly  = 16'hFFFF;
        3: hold = 0;
        4: dly  = 0;
        5: hold = 1;
        7: hold = 8'hFF;
        default: ;
      endcase
      write_cfg(thr, hold, dly);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          base_x = $urandom_range(0, SAMPLE_MAX);
          base_y = $urandom_range(0, SAMPLE_MAX);
          base_z = $urandom_range(0, SAMPLE_MAX);
        end
        if (pick >= 8 && pick < 14) begin
          x = $urandom_range(0, SAMPLE_MAX);
          y = $urandom_range(0, SAMPLE_MAX);
          z = $urandom_range(0, SAMPLE_MAX);
        end else begin
          x = base_x ^ $urandom_range(0, 7);
          y = base_y ^ $urandom_range(0, 7);
          z = base_z ^ $urandom_range(0, 7);
        end
        if (phase == 3 && n == 40) stall_request = 1'b1;
        send_tick(x, y, z, $urandom_range(0, 11) == 0);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Covered %0d ticks over %0d register settings: %0d impacts, %0d alerts, %0d cancels.",
             board.ticks, settings, board.impacts, board.alerts, board.cancels);
    $display("Long receiver hold-offs: %0d of %0d cycles; mismatches: %0d.",
             long_holds, LONG_HOLD, board.failures);
    if (board.failures == 0 && board.pending_results.size() == 0)
      $display("impact_detector_with_holdoff_unit regression: pass");
    else
      $display("impact_detector_with_holdoff_unit regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/idh_pkg.sv
rtl/idh_if.sv
rtl/idh_cfg.sv
rtl/idh_sqrt.sv
rtl/impact_detector_with_holdoff_unit.sv
tb/tb_impact_detector_with_holdoff_unit.sv
